[rtl/dsrb_pkg.sv]
// shared types, codes and sizes of the deduplicating sorted record builder
`default_nettype none

package dsrb_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int AW        = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam int ITEM_W    = 24;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 6;
  localparam int ICNT_W    = 7;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_ZERO  = 2'd2;

  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_ELEMENT = 1'b1;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [ITEM_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        status;
    logic [ITEM_W-1:0] item;
    logic [POS_W-1:0]  position;
    logic [ICNT_W-1:0] item_count;
    logic [WORD_W-1:0] customer;
    logic              customer_valid;
    logic [WORD_W-1:0] record;
    logic              last;
  } out_beat_t;

endpackage

`default_nettype wire

[rtl/dedup_sorted_record_builder.sv]
// top level of the deduplicating sorted record builder
//
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | op, item, customer id, record choice
// out_    | output    | out_valid/out_stall | add status or one flushed element
// cfg_    | input     | cfg_we              | emit_customer_id bit
//
// add: scans held entries below the new item (read, then compare), shifts each entry above the
//   insert point up (read, then write), writes the item; dup or full gives just the status beat
// flush: memory read, then output register load, per element; other ops act in the idle state
// input taken only when the sequencer is idle; a pending output beat does not block it
// out_stall holds the output register and stalls the step that wants to load it
// synchronous active-low reset clears count, counter and handshake state; no clearing pass
`default_nettype none

module dedup_sorted_record_builder (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_op,
  input  wire logic [dsrb_pkg::ITEM_W-1:0]     in_item,
  input  wire logic [dsrb_pkg::WORD_W-1:0]     in_customer_id,
  input  wire logic                            in_use_given_record,
  input  wire logic [dsrb_pkg::WORD_W-1:0]     in_given_record,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_kind,
  output logic [1:0]                           out_status,
  output logic [dsrb_pkg::ITEM_W-1:0]          out_item,
  output logic [dsrb_pkg::POS_W-1:0]           out_position,
  output logic [dsrb_pkg::ICNT_W-1:0]          out_item_count,
  output logic [dsrb_pkg::WORD_W-1:0]          out_customer,
  output logic                                 out_customer_valid,
  output logic [dsrb_pkg::WORD_W-1:0]          out_record,
  output logic                                 out_last
);

  dsrb_pkg::mem_req_t            mem_req;
  logic [dsrb_pkg::ITEM_W-1:0]   mem_rdata;
  dsrb_pkg::out_beat_t           beat;

  dsrb_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  dsrb_seq u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_item             (in_item),
    .in_customer_id      (in_customer_id),
    .in_use_given_record (in_use_given_record),
    .in_given_record     (in_given_record),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_beat            (beat),
    .mem_req             (mem_req),
    .mem_rdata           (mem_rdata)
  );

  assign out_kind           = beat.kind;
  assign out_status         = beat.status;
  assign out_item           = beat.item;
  assign out_position       = beat.position;
  assign out_item_count     = beat.item_count;
  assign out_customer       = beat.customer;
  assign out_customer_valid = beat.customer_valid;
  assign out_record         = beat.record;
  assign out_last           = beat.last;

endmodule

`default_nettype wire

[rtl/dsrb_store.sv]
// item store with one read and one write port and registered read data
`default_nettype none

module dsrb_store (
  input  wire logic                      clk,
  input  wire dsrb_pkg::mem_req_t        req,
  output logic [dsrb_pkg::ITEM_W-1:0]    rdata
);

  logic [dsrb_pkg::ITEM_W-1:0] mem [dsrb_pkg::MAX_ITEMS];
  logic [dsrb_pkg::ITEM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/dsrb_seq.sv]
// sequencer: scan, shift-insert, flush walk, counters and output register
`default_nettype none

module dsrb_seq (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_op,
  input  wire logic [dsrb_pkg::ITEM_W-1:0]     in_item,
  input  wire logic [dsrb_pkg::WORD_W-1:0]     in_customer_id,
  input  wire logic                            in_use_given_record,
  input  wire logic [dsrb_pkg::WORD_W-1:0]     in_given_record,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output dsrb_pkg::out_beat_t                  out_beat,
  output dsrb_pkg::mem_req_t                   mem_req,
  input  wire logic [dsrb_pkg::ITEM_W-1:0]     mem_rdata
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CMP = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_RESULT   = 3'd5;
  localparam logic [2:0] S_EMIT_RD  = 3'd6;
  localparam logic [2:0] S_EMIT_LD  = 3'd7;

  localparam logic [dsrb_pkg::CNT_W-1:0] FULL_CNT = dsrb_pkg::CNT_W'(dsrb_pkg::MAX_ITEMS);
  localparam logic [dsrb_pkg::CNT_W-1:0] ONE_CNT  = dsrb_pkg::CNT_W'(1);

  localparam logic [1:0] OP_ADD_C   = dsrb_pkg::OP_ADD;
  localparam logic [1:0] OP_FLUSH_C = dsrb_pkg::OP_FLUSH;
  localparam logic [1:0] OP_ZERO_C  = dsrb_pkg::OP_ZERO;

  logic [2:0]                     state_r, state_nxt;
  logic [dsrb_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [dsrb_pkg::WORD_W-1:0]    ctr_r, ctr_nxt;
  logic                           emit_r;
  logic                           out_valid_r, out_valid_nxt;

  logic [dsrb_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic [dsrb_pkg::CNT_W-1:0]     pos_r, pos_nxt;
  logic [dsrb_pkg::CNT_W-1:0]     n_r, n_nxt;
  logic [1:0]                     status_r, status_nxt;
  logic [dsrb_pkg::ITEM_W-1:0]    item_r, item_nxt;
  logic [dsrb_pkg::WORD_W-1:0]    cust_r, cust_nxt;
  logic [dsrb_pkg::WORD_W-1:0]    rec_r, rec_nxt;
  dsrb_pkg::out_beat_t            out_r, out_nxt;

  logic [dsrb_pkg::WORD_W-1:0]    ctr_inc;
  logic [dsrb_pkg::CNT_W-1:0]     idx_dec;
  logic                           out_free;
  logic                           emit_last;

  assign ctr_inc   = ctr_r + dsrb_pkg::WORD_W'(1);
  assign idx_dec   = idx_r - ONE_CNT;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_last = (idx_r == (n_r - ONE_CNT));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ctr_nxt       = ctr_r;
    out_valid_nxt = out_valid_r && out_stall;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    n_nxt         = n_r;
    status_nxt    = status_r;
    item_nxt      = item_r;
    cust_nxt      = cust_r;
    rec_nxt       = rec_r;
    out_nxt       = out_r;
    mem_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_item;
          case (in_op)
            OP_ADD_C: begin
              idx_nxt   = '0;
              state_nxt = S_SCAN_RD;
            end
            OP_FLUSH_C: begin
              if (count_r != '0) begin
                ctr_nxt   = ctr_inc;
                cust_nxt  = (in_customer_id == '0) ? ctr_inc : in_customer_id;
                rec_nxt   = in_use_given_record ? in_given_record : ctr_inc;
                n_nxt     = count_r;
                idx_nxt   = '0;
                state_nxt = S_EMIT_RD;
              end
            end
            OP_ZERO_C: begin
              ctr_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          // ran past every held entry: new item goes at the end unless the store is full
          pos_nxt = idx_r;
          if (count_r == FULL_CNT) begin
            status_nxt = dsrb_pkg::ST_FULL;
            state_nxt  = S_RESULT;
          end else begin
            idx_nxt   = count_r;
            state_nxt = S_SHIFT_RD;
          end
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_r[dsrb_pkg::AW-1:0];
          state_nxt     = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (mem_rdata == item_r) begin
          status_nxt = dsrb_pkg::ST_DUP;
          state_nxt  = S_RESULT;
        end else if (mem_rdata > item_r) begin
          pos_nxt = idx_r;
          if (count_r == FULL_CNT) begin
            status_nxt = dsrb_pkg::ST_FULL;
            state_nxt  = S_RESULT;
          end else begin
            idx_nxt   = count_r;
            state_nxt = S_SHIFT_RD;
          end
        end else begin
          idx_nxt   = idx_r + ONE_CNT;
          state_nxt = S_SCAN_RD;
        end
      end

      S_SHIFT_RD: begin
        if (idx_r == pos_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r[dsrb_pkg::AW-1:0];
          mem_req.wdata = item_r;
          count_nxt     = count_r + ONE_CNT;
          status_nxt    = dsrb_pkg::ST_ADDED;
          state_nxt     = S_RESULT;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_dec[dsrb_pkg::AW-1:0];
          state_nxt     = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        // move the entry below up by one; read and write never hit the same entry
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r[dsrb_pkg::AW-1:0];
        mem_req.wdata = mem_rdata;
        idx_nxt       = idx_dec;
        state_nxt     = S_SHIFT_RD;
      end

      S_RESULT: begin
        if (out_free) begin
          out_nxt        = '0;
          out_nxt.kind   = dsrb_pkg::KIND_STATUS;
          out_nxt.status = status_r;
          out_nxt.last   = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_EMIT_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_r[dsrb_pkg::AW-1:0];
        state_nxt     = S_EMIT_LD;
      end

      S_EMIT_LD: begin
        if (out_free) begin
          out_nxt.kind           = dsrb_pkg::KIND_ELEMENT;
          out_nxt.status         = dsrb_pkg::ST_ADDED;
          out_nxt.item           = mem_rdata;
          out_nxt.position       = dsrb_pkg::POS_W'(idx_r);
          out_nxt.item_count     = dsrb_pkg::ICNT_W'(n_r);
          out_nxt.customer       = cust_r;
          out_nxt.customer_valid = emit_r;
          out_nxt.record         = rec_r;
          out_nxt.last           = emit_last;
          out_valid_nxt          = 1'b1;
          if (emit_last) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + ONE_CNT;
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ctr_r       <= '0;
      emit_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        emit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    n_r      <= n_nxt;
    status_r <= status_nxt;
    item_r   <= item_nxt;
    cust_r   <= cust_nxt;
    rec_r    <= rec_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("held count above store depth");

  a_shift_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_RD || state_r == S_SHIFT_WR) |-> (count_r < FULL_CNT))
    else $error("shift started on a full store");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_RD || state_r == S_EMIT_LD) |-> (idx_r < n_r && n_r != '0))
    else $error("flush walk outside held entries");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_LD && out_free && emit_last) |=>
      (count_r == '0 && state_r == S_IDLE && out_valid_r && out_r.last))
    else $error("final flush beat did not empty the store");

endmodule

`default_nettype wire
